>>> rtl/core/count_quantile_sum_scaling_defines.svh
// Assertion helpers for the cumulative sum scaling block.
// Each macro expects clk and rst_n in scope.
`ifndef COUNT_QUANTILE_SUM_SCALING_DEFINES_SVH
`define COUNT_QUANTILE_SUM_SCALING_DEFINES_SVH

// cond must never hold outside reset
`define CQSS_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("cqss: forbidden condition seen");

// ante on one edge requires cons on the next edge
`define CQSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cqss: expected follow-up missing");

`endif

>>> rtl/core/cqss_pkg.sv
// ----------------------------------------------------------------------------
// cqss_pkg
// Types and constants for the cumulative sum scaling block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cqss_pkg;

  localparam int MAX_ROWS_DEF   = 1024;
  localparam int COUNT_BITS_DEF = 24;

  localparam int FACTOR_W = 21;
  localparam int SUM_W    = 34;
  localparam int SCALED_W = 32;

  localparam logic [FACTOR_W-1:0] FACTOR_RESET = 21'd1000;

  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_FINISH = 2'd1;
  localparam logic [1:0] ACT_READ   = 2'd2;

  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_DROPPED  = 2'd1;
  localparam logic [1:0] ERR_RANGE    = 2'd2;

  localparam logic KIND_SUMMARY = 1'b0;
  localparam logic KIND_SCALED  = 1'b1;

  typedef struct packed {
    logic [1:0]  action;
    logic [23:0] count_value;
    logic [9:0]  entry_index;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [23:0] quantile_value;
    logic [33:0] capped_sum;
    logic [31:0] scaled_value;
    logic        saturated;
    logic [1:0]  error_code;
  } out_item_t;

endpackage

>>> rtl/core/count_quantile_sum_scaling.sv
// ----------------------------------------------------------------------------
// count_quantile_sum_scaling
// Column store with median-of-nonzero search, capped sum and scaled reads.
//
// channel | dir | handshake            | payload
// in      | in  | in_valid / in_stall  | in_data  (action, count, index)
// out     | out | out_valid / out_stall| out_data (summary or scaled entry)
// cfg     | in  | cfg_wr_en            | cfg_wr_data (scale factor)
//
// Loads are taken back to back. A scaled read forms the product, then runs the
// bit-serial divider unless the count or sum is zero. Finish makes (SW + 2)
// sweeps over the store, through the single memory read port.
// Synchronous active-low reset clears control; the store has no reset.
// A result held in the output register does not block the next load; a new
// result waits for the output register to free, and inputs stall meanwhile.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "count_quantile_sum_scaling_defines.svh"

module count_quantile_sum_scaling #(
  parameter int MAX_ROWS   = cqss_pkg::MAX_ROWS_DEF,
  parameter int COUNT_BITS = cqss_pkg::COUNT_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  cqss_pkg::in_item_t           in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output cqss_pkg::out_item_t          out_data,
  input  logic                         cfg_wr_en,
  input  logic [cqss_pkg::FACTOR_W-1:0] cfg_wr_data
);
  import cqss_pkg::*;

  localparam int SW   = (COUNT_BITS < 24) ? COUNT_BITS : 24;
  localparam int AW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int TW   = $clog2(MAX_ROWS + 1);
  localparam int IXW  = (AW > 10) ? AW : 10;
  localparam int CMPW = (TW > 10) ? TW : 10;
  localparam int PW   = SW + FACTOR_W;
  localparam int DCW  = $clog2(PW + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_NZ, ST_RDX, ST_SUM, ST_MUL, ST_DIV, ST_SAT, ST_RESULT
  } state_t;

  state_t             state_r;
  logic [SW-1:0]      mem [MAX_ROWS];
  logic [SW-1:0]      rd_data_r;
  logic [AW-1:0]      rd_addr;
  logic [TW-1:0]      total_r, scan_r, cnt_r, k_r;
  logic               dvld_r;
  logic [SW-1:0]      prefix_r, hi_mask_r, bit_r;
  logic [SUM_W-1:0]   sum_hold_r, sum_acc_r;
  logic               done_r, ovf_r;
  logic [FACTOR_W-1:0] factor_r;
  logic [PW-1:0]      quo_r;
  logic [SUM_W-1:0]   rem_r;
  logic [DCW-1:0]     div_cnt_r;
  out_item_t          res_r, out_data_r;
  logic               out_valid_r;

  logic               in_acc, out_free, issue, pass_end;
  logic [TW-1:0]      load_base;
  logic [IXW-1:0]     idx_w;
  logic [CMPW-1:0]    idx_c, total_c;
  logic               rdx_match;
  logic [SUM_W:0]     sum_add;
  logic [SUM_W:0]     rem_sh;
  logic [63:0]        quo64;
  logic [TW:0]        nz_inc;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // sweep control shared by the finish passes
  assign issue    = (scan_r < total_r);
  assign pass_end = !issue && !dvld_r;

  assign load_base = done_r ? '0 : total_r;
  assign idx_w     = IXW'(in_data.entry_index);
  assign idx_c     = CMPW'(in_data.entry_index);
  assign total_c   = CMPW'(total_r);
  assign rd_addr   = (state_r == ST_IDLE) ? idx_w[AW-1:0] : scan_r[AW-1:0];

  assign rdx_match = (rd_data_r != '0) && (((rd_data_r ^ prefix_r) & hi_mask_r) == '0)
                     && ((rd_data_r & bit_r) == '0);
  assign sum_add   = {1'b0, sum_acc_r} + (SUM_W+1)'(rd_data_r);
  assign rem_sh    = {rem_r, quo_r[PW-1]};
  assign quo64     = 64'(quo_r);
  assign nz_inc    = {1'b0, cnt_r} + 1'b1;

  // count store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_acc && in_data.action == ACT_LOAD &&
        load_base < TW'(MAX_ROWS)) begin
      mem[load_base[AW-1:0]] <= in_data.count_value[SW-1:0];
    end
    rd_data_r <= mem[rd_addr];
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      factor_r <= FACTOR_RESET;
    end else if (cfg_wr_en) begin
      factor_r <= cfg_wr_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_RESULT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_RESULT && out_free) begin
      out_data_r <= res_r;
    end
  end

  // sequencer: loads, finish sweeps, scaled reads
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      total_r    <= '0;
      sum_hold_r <= '0;
      done_r     <= 1'b0;
      ovf_r      <= 1'b0;
      scan_r     <= '0;
      dvld_r     <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          scan_r <= '0;
          dvld_r <= 1'b0;
          if (in_acc) begin
            case (in_data.action)
              ACT_LOAD: begin
                if (done_r) begin
                  sum_hold_r <= '0;
                  done_r     <= 1'b0;
                end
                if (load_base < TW'(MAX_ROWS)) begin
                  total_r <= load_base + 1'b1;
                  ovf_r   <= done_r ? 1'b0 : ovf_r;
                end else begin
                  total_r <= load_base;
                  ovf_r   <= 1'b1;
                end
              end
              ACT_FINISH: begin
                res_r   <= '0;
                cnt_r   <= '0;
                state_r <= ST_NZ;
              end
              ACT_READ: begin
                res_r <= '{result_kind: KIND_SCALED, quantile_value: '0,
                           capped_sum: '0, scaled_value: '0, saturated: 1'b0,
                           error_code: (idx_c >= total_c) ? ERR_RANGE : ERR_OK};
                if (idx_c >= total_c) begin
                  state_r <= ST_RESULT;
                end else begin
                  state_r <= ST_MUL;
                end
              end
              default: ;
            endcase
          end
        end

        // count nonzero entries
        ST_NZ: begin
          scan_r <= issue ? scan_r + 1'b1 : (pass_end ? '0 : scan_r);
          dvld_r <= issue;
          if (dvld_r && rd_data_r != '0) begin
            cnt_r <= cnt_r + 1'b1;
          end
          if (pass_end) begin
            k_r       <= nz_inc[TW:1];
            cnt_r     <= '0;
            prefix_r  <= '0;
            hi_mask_r <= '0;
            bit_r     <= {1'b1, {(SW-1){1'b0}}};
            state_r   <= ST_RDX;
          end
        end

        // radix select, one bit of the quantile per sweep
        ST_RDX: begin
          scan_r <= issue ? scan_r + 1'b1 : (pass_end ? '0 : scan_r);
          dvld_r <= issue;
          if (dvld_r && rdx_match) begin
            cnt_r <= cnt_r + 1'b1;
          end
          if (pass_end) begin
            if (k_r > cnt_r) begin
              prefix_r <= prefix_r | bit_r;
              k_r      <= k_r - cnt_r;
            end
            hi_mask_r <= hi_mask_r | bit_r;
            bit_r     <= bit_r >> 1;
            cnt_r     <= '0;
            sum_acc_r <= '0;
            if (bit_r[0]) begin
              state_r <= ST_SUM;
            end
          end
        end

        // saturating sum of entries not above the quantile
        ST_SUM: begin
          scan_r <= issue ? scan_r + 1'b1 : scan_r;
          dvld_r <= issue;
          if (dvld_r && rd_data_r <= prefix_r) begin
            sum_acc_r <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
          end
          if (pass_end) begin
            sum_hold_r           <= sum_acc_r;
            done_r               <= 1'b1;
            res_r.result_kind    <= KIND_SUMMARY;
            res_r.quantile_value <= 24'(prefix_r);
            res_r.capped_sum     <= sum_acc_r;
            res_r.error_code     <= ovf_r ? ERR_DROPPED : ERR_OK;
            state_r              <= ST_RESULT;
          end
        end

        // product of count and factor
        ST_MUL: begin
          quo_r     <= PW'(rd_data_r) * PW'(factor_r);
          rem_r     <= '0;
          div_cnt_r <= DCW'(PW);
          if (rd_data_r == '0 || sum_hold_r == '0) begin
            state_r <= ST_RESULT;
          end else begin
            state_r <= ST_DIV;
          end
        end

        // restoring division, one quotient bit per cycle
        ST_DIV: begin
          if (rem_sh >= {1'b0, sum_hold_r}) begin
            rem_r <= SUM_W'(rem_sh - {1'b0, sum_hold_r});
            quo_r <= {quo_r[PW-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh[SUM_W-1:0];
            quo_r <= {quo_r[PW-2:0], 1'b0};
          end
          div_cnt_r <= div_cnt_r - 1'b1;
          if (div_cnt_r == DCW'(1)) begin
            state_r <= ST_SAT;
          end
        end

        // clip the quotient to 32 bits
        ST_SAT: begin
          res_r.scaled_value <= (quo64[63:32] != '0) ? '1 : quo64[31:0];
          res_r.saturated    <= (quo64[63:32] != '0);
          state_r            <= ST_RESULT;
        end

        ST_RESULT: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

  `CQSS_ASSERT_NEVER(a_total_cap, total_r > TW'(MAX_ROWS))
  `CQSS_ASSERT_NEXT(a_out_hold, out_valid_r && out_stall,
                    out_valid_r && $stable(out_data_r))
  `CQSS_ASSERT_NEVER(a_div_count, state_r == ST_DIV && div_cnt_r == '0)

endmodule
